/* rtl/hte_pkg.sv */
// Shared types and constants for the TCP/IPv4 header extractor.
`timescale 1ns / 1ps

package hte_pkg;

  // Frame position counter width and default position limit
  localparam int unsigned POS_W                = 16;
  localparam int unsigned MAX_FRAME_BYTES_DEF  = 65535;

  // Header geometry
  localparam logic [POS_W-1:0] ETH_HDR_BYTES   = 16'd14;
  localparam logic [5:0]       MIN_HDR_BYTES   = 6'd20;

  // Byte positions inside the frame
  localparam logic [POS_W-1:0] POS_ETYPE_HI    = 16'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO    = 16'd13;
  localparam logic [POS_W-1:0] POS_IHL         = 16'd14;
  localparam logic [POS_W-1:0] POS_PROTO       = 16'd23;
  localparam logic [POS_W-1:0] POS_SRC_FIRST   = 16'd26;
  localparam logic [POS_W-1:0] POS_SRC_LAST    = 16'd29;
  localparam logic [POS_W-1:0] POS_DST_FIRST   = 16'd30;
  localparam logic [POS_W-1:0] POS_DST_LAST    = 16'd33;
  localparam logic [POS_W-1:0] POS_TCP_GATE    = 16'd24;

  // Offsets inside the TCP header
  localparam logic [POS_W-1:0] TCP_SPORT_LAST  = 16'd1;
  localparam logic [POS_W-1:0] TCP_DPORT_LAST  = 16'd3;
  localparam logic [POS_W-1:0] TCP_SEQ_LAST    = 16'd7;
  localparam logic [POS_W-1:0] TCP_ACK_LAST    = 16'd11;
  localparam logic [POS_W-1:0] TCP_DOFF        = 16'd12;

  // Expected header values
  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP     = 8'd6;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_IPV4   = 3'd1,
    ST_BAD_IP_LEN = 3'd2,
    ST_NOT_TCP    = 3'd3,
    ST_BAD_TCP    = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_t;

  // One input word as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  // One parse result
  typedef struct packed {
    status_t     status;
    logic [5:0]  ip_hdr_bytes;
    logic [5:0]  tcp_hdr_bytes;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [31:0] pkt_num;
  } result_t;

endpackage

/* rtl/hte_in_stage.sv */
// Input register for the byte stream.
`timescale 1ns / 1ps

module hte_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  hte_pkg::in_word_t s_word,
  input  logic              advance,
  output logic              word_valid,
  output hte_pkg::in_word_t word
);
  import hte_pkg::*;

  logic accept;

  // Take a new word when empty or when the held word moves on
  assign s_ready = !word_valid || advance;
  assign accept  = s_valid && s_ready;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (accept) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (accept) begin
      word <= s_word;
    end
  end

endmodule

/* rtl/hte_parser.sv */
// Per-frame header parse state and capture logic.
`timescale 1ns / 1ps

module hte_parser #(
  parameter int unsigned MAX_FRAME_BYTES = hte_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  hte_pkg::in_word_t word,
  output logic              emit,
  output hte_pkg::result_t  result
);
  import hte_pkg::*;

  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [5:0]       ip_len, ip_len_next;
  logic [5:0]       tcp_len, tcp_len_next;
  logic [31:0]      src_addr, src_addr_next;
  logic [31:0]      dst_addr, dst_addr_next;
  logic [15:0]      src_port, src_port_next;
  logic [15:0]      dst_port, dst_port_next;
  logic [31:0]      seq_num, seq_num_next;
  logic [31:0]      ack_num, ack_num_next;
  status_t          verdict, verdict_next;
  logic [31:0]      frame_count, frame_count_next;

  // Examine one byte, build the result on the last byte of a frame
  always_comb begin
    logic [POS_W-1:0] tcp_base;
    logic [POS_W-1:0] rel;
    status_t          st;

    tcp_base         = ETH_HDR_BYTES + {{(POS_W-6){1'b0}}, ip_len};
    rel              = byte_pos - tcp_base;
    st               = ST_OK;

    byte_pos_next    = byte_pos;
    ip_len_next      = ip_len;
    tcp_len_next     = tcp_len;
    src_addr_next    = src_addr;
    dst_addr_next    = dst_addr;
    src_port_next    = src_port;
    dst_port_next    = dst_port;
    seq_num_next     = seq_num;
    ack_num_next     = ack_num;
    verdict_next     = verdict;
    frame_count_next = frame_count;
    emit             = 1'b0;
    result           = '0;

    if (step) begin
      // Bytes past the limit are dropped and the position saturates
      if (byte_pos < POS_W'(MAX_FRAME_BYTES)) begin
        byte_pos_next = byte_pos + 1'b1;
        // First rejection wins: skip all checks and captures after it
        if (verdict == ST_OK) begin
          priority if (byte_pos == POS_ETYPE_HI) begin
            if (word.data != ETYPE_IPV4_HI) verdict_next = ST_NOT_IPV4;
          end else if (byte_pos == POS_ETYPE_LO) begin
            if (word.data != ETYPE_IPV4_LO) verdict_next = ST_NOT_IPV4;
          end else if (byte_pos == POS_IHL) begin
            ip_len_next = {word.data[3:0], 2'b00};
            if ({word.data[3:0], 2'b00} < MIN_HDR_BYTES) verdict_next = ST_BAD_IP_LEN;
          end else if (byte_pos == POS_PROTO) begin
            if (word.data != PROTO_TCP) verdict_next = ST_NOT_TCP;
          end else if (byte_pos >= POS_SRC_FIRST && byte_pos <= POS_SRC_LAST) begin
            src_addr_next = {src_addr[23:0], word.data};
          end else if (byte_pos >= POS_DST_FIRST && byte_pos <= POS_DST_LAST) begin
            dst_addr_next = {dst_addr[23:0], word.data};
          end else begin
          end

          // TCP header fields, located behind the IPv4 header
          if (byte_pos >= POS_TCP_GATE && ip_len >= MIN_HDR_BYTES &&
              byte_pos >= tcp_base) begin
            priority if (rel <= TCP_SPORT_LAST) begin
              src_port_next = {src_port[7:0], word.data};
            end else if (rel <= TCP_DPORT_LAST) begin
              dst_port_next = {dst_port[7:0], word.data};
            end else if (rel <= TCP_SEQ_LAST) begin
              seq_num_next = {seq_num[23:0], word.data};
            end else if (rel <= TCP_ACK_LAST) begin
              ack_num_next = {ack_num[23:0], word.data};
            end else if (rel == TCP_DOFF) begin
              tcp_len_next = {word.data[7:4], 2'b00};
              if ({word.data[7:4], 2'b00} < MIN_HDR_BYTES) verdict_next = ST_BAD_TCP;
            end else begin
            end
          end
        end
      end

      // Close the frame: report and clear per-frame state
      if (word.last) begin
        frame_count_next = frame_count + 1'b1;
        priority if (verdict_next != ST_OK) begin
          st = verdict_next;
        end else if (tcp_len_next == '0) begin
          st = ST_TRUNCATED;
        end else begin
          st = ST_OK;
        end

        emit                 = 1'b1;
        result.status        = st;
        result.ip_hdr_bytes  = ip_len_next;
        result.tcp_hdr_bytes = tcp_len_next;
        result.pkt_num       = frame_count_next;
        if (st == ST_OK) begin
          result.src_addr = src_addr_next;
          result.dst_addr = dst_addr_next;
          result.src_port = src_port_next;
          result.dst_port = dst_port_next;
          result.seq_num  = seq_num_next;
          result.ack_num  = ack_num_next;
        end

        byte_pos_next = '0;
        ip_len_next   = '0;
        tcp_len_next  = '0;
        src_addr_next = '0;
        dst_addr_next = '0;
        src_port_next = '0;
        dst_port_next = '0;
        seq_num_next  = '0;
        ack_num_next  = '0;
        verdict_next  = ST_OK;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      ip_len      <= '0;
      tcp_len     <= '0;
      src_addr    <= '0;
      dst_addr    <= '0;
      src_port    <= '0;
      dst_port    <= '0;
      seq_num     <= '0;
      ack_num     <= '0;
      verdict     <= ST_OK;
      frame_count <= '0;
    end else begin
      byte_pos    <= byte_pos_next;
      ip_len      <= ip_len_next;
      tcp_len     <= tcp_len_next;
      src_addr    <= src_addr_next;
      dst_addr    <= dst_addr_next;
      src_port    <= src_port_next;
      dst_port    <= dst_port_next;
      seq_num     <= seq_num_next;
      ack_num     <= ack_num_next;
      verdict     <= verdict_next;
      frame_count <= frame_count_next;
    end
  end

endmodule

/* rtl/hte_out_stage.sv */
// Output register holding one parse result.
`timescale 1ns / 1ps

module hte_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  hte_pkg::result_t load_result,
  output logic             free,
  output logic             m_valid,
  input  logic             m_ready,
  output hte_pkg::result_t m_result
);
  import hte_pkg::*;

  // Slot can take a new result when empty or being drained
  assign free = !m_valid || m_ready;

  // Hold valid until the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  // Load payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_result <= load_result;
    end
  end

endmodule

/* rtl/tcp_ipv4_header_extractor.sv */
// Top level: Ethernet/IPv4/TCP header extractor with byte stream in, result stream out.
// A frame's result passes from the input register through the parser into the output register.
// Throughput: one byte per cycle while no last byte waits, set by the position compare and capture stage.
// A frame's last byte waits only while the output register holds an untaken result.
// Reset (rst, synchronous): clears input and output valid flags, frame state and frame count.
`timescale 1ns / 1ps

module tcp_ipv4_header_extractor #(
  parameter int unsigned MAX_FRAME_BYTES = hte_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic         s_axis_tlast,   // frame_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ip_header_bytes[5:0], tcp_header_bytes[11:6], source_address[43:12],
  // destination_address[75:44], source_port[91:76], destination_port[107:92],
  // sequence_number[139:108], acknowledgement_number[171:140],
  // packet_number[203:172], zero pad[207:204]
  output logic [207:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser    // status[2:0]
);
  import hte_pkg::*;

  in_word_t s_word;
  in_word_t word;
  logic     word_valid;
  logic     advance;
  logic     out_free;
  logic     emit;
  result_t  result;
  result_t  m_result;

  assign s_word.data = s_axis_tdata;
  assign s_word.last = s_axis_tlast;

  // Advance a held byte; a last byte also needs room for its result
  assign advance = word_valid && (!word.last || out_free);

  hte_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_word     (s_word),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  hte_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (word),
    .emit   (emit),
    .result (result)
  );

  hte_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (emit),
    .load_result (result),
    .free        (out_free),
    .m_valid     (m_axis_tvalid),
    .m_ready     (m_axis_tready),
    .m_result    (m_result)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {4'b0000, m_result.pkt_num, m_result.ack_num, m_result.seq_num,
                         m_result.dst_port, m_result.src_port, m_result.dst_addr,
                         m_result.src_addr, m_result.tcp_hdr_bytes, m_result.ip_hdr_bytes};
  assign m_axis_tuser = m_result.status;

endmodule

/* test/header_result_checker.sv */
// Stream monitor for the header extractor: predicts each frame's result word and compares.
`timescale 1ns / 1ps

module header_result_checker #(
  parameter int unsigned FRAME_LIMIT = 65535
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic         s_axis_tlast,   // frame_end
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ip_header_bytes[5:0], tcp_header_bytes[11:6], source_address[43:12],
  // destination_address[75:44], source_port[91:76], destination_port[107:92],
  // sequence_number[139:108], acknowledgement_number[171:140],
  // packet_number[203:172], zero pad[207:204]
  input  logic [207:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,   // status[2:0]
  output int           mismatch_count,
  output int           pending_results
);
  import hte_pkg::*;

  // Frame byte positions and header geometry
  localparam int ETYPE_HI_AT    = 12;
  localparam int ETYPE_LO_AT    = 13;
  localparam int IHL_AT         = 14;
  localparam int PROTO_AT       = 23;
  localparam int SRC_ADDR_FIRST = 26;
  localparam int SRC_ADDR_END   = 29;
  localparam int DST_ADDR_FIRST = 30;
  localparam int DST_ADDR_END   = 33;
  localparam int TCP_SCAN_FROM  = 24;
  localparam int ETH_HEADER_LEN = 14;
  localparam int MIN_HEADER_LEN = 20;

  // Offsets inside the TCP header
  localparam int SPORT_END = 1;
  localparam int DPORT_END = 3;
  localparam int SEQ_END   = 7;
  localparam int ACK_END   = 11;
  localparam int DOFF_AT   = 12;

  localparam int PRINT_LIMIT = 100;

  // Per-frame parse state
  int unsigned frame_pos;
  logic [5:0]  ip_len;
  logic [5:0]  tcp_len;
  logic [31:0] src_acc;
  logic [31:0] dst_acc;
  logic [15:0] sport_acc;
  logic [15:0] dport_acc;
  logic [31:0] seq_acc;
  logic [31:0] ack_acc;
  status_t     first_reject;
  logic [31:0] frames_done;

  result_t     expected_headers[$];

  initial mismatch_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic start_new_frame();
    frame_pos    = 0;
    ip_len       = '0;
    tcp_len      = '0;
    src_acc      = '0;
    dst_acc      = '0;
    sport_acc    = '0;
    dport_acc    = '0;
    seq_acc      = '0;
    ack_acc      = '0;
    first_reject = ST_OK;
  endtask

  always @(posedge clk) begin : predict_and_compare
    result_t     want;
    int unsigned rel;
    if (rst) begin
      start_new_frame();
      frames_done = '0;
      expected_headers.delete();
    end else begin
      // Compare a taken result word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_headers.size() == 0) begin
          report_mismatch("result word with no frame outstanding", m_axis_tdata[203:172],
                          32'd0);
        end else begin
          want = expected_headers.pop_front();
          check_field("status", 32'(m_axis_tuser), 32'(want.status));
          check_field("ip_header_bytes", 32'(m_axis_tdata[5:0]), 32'(want.ip_hdr_bytes));
          check_field("tcp_header_bytes", 32'(m_axis_tdata[11:6]), 32'(want.tcp_hdr_bytes));
          check_field("source_address", m_axis_tdata[43:12], want.src_addr);
          check_field("destination_address", m_axis_tdata[75:44], want.dst_addr);
          check_field("source_port", 32'(m_axis_tdata[91:76]), 32'(want.src_port));
          check_field("destination_port", 32'(m_axis_tdata[107:92]), 32'(want.dst_port));
          check_field("sequence_number", m_axis_tdata[139:108], want.seq_num);
          check_field("acknowledgement_number", m_axis_tdata[171:140], want.ack_num);
          check_field("packet_number", m_axis_tdata[203:172], want.pkt_num);
          check_field("tdata pad", 32'(m_axis_tdata[207:204]), 32'd0);
        end
      end

      // Advance the parse on an accepted byte
      if (s_axis_tvalid && s_axis_tready) begin
        if (frame_pos < FRAME_LIMIT) begin
          // Skip all checks and captures once the frame is rejected
          if (first_reject == ST_OK) begin
            if (frame_pos == ETYPE_HI_AT) begin
              if (s_axis_tdata != ETYPE_IPV4_HI) first_reject = ST_NOT_IPV4;
            end else if (frame_pos == ETYPE_LO_AT) begin
              if (s_axis_tdata != ETYPE_IPV4_LO) first_reject = ST_NOT_IPV4;
            end else if (frame_pos == IHL_AT) begin
              // version nibble is not checked
              ip_len = {s_axis_tdata[3:0], 2'b00};
              if (ip_len < MIN_HEADER_LEN) first_reject = ST_BAD_IP_LEN;
            end else if (frame_pos == PROTO_AT) begin
              if (s_axis_tdata != PROTO_TCP) first_reject = ST_NOT_TCP;
            end else if (frame_pos >= SRC_ADDR_FIRST && frame_pos <= SRC_ADDR_END) begin
              src_acc = {src_acc[23:0], s_axis_tdata};
            end else if (frame_pos >= DST_ADDR_FIRST && frame_pos <= DST_ADDR_END) begin
              dst_acc = {dst_acc[23:0], s_axis_tdata};
            end

            // TCP header starts right after the IPv4 header
            if (frame_pos >= TCP_SCAN_FROM && ip_len >= MIN_HEADER_LEN &&
                frame_pos >= ETH_HEADER_LEN + ip_len) begin
              rel = frame_pos - ETH_HEADER_LEN - ip_len;
              if (rel <= SPORT_END) begin
                sport_acc = {sport_acc[7:0], s_axis_tdata};
              end else if (rel <= DPORT_END) begin
                dport_acc = {dport_acc[7:0], s_axis_tdata};
              end else if (rel <= SEQ_END) begin
                seq_acc = {seq_acc[23:0], s_axis_tdata};
              end else if (rel <= ACK_END) begin
                ack_acc = {ack_acc[23:0], s_axis_tdata};
              end else if (rel == DOFF_AT) begin
                tcp_len = {s_axis_tdata[7:4], 2'b00};
                if (tcp_len < MIN_HEADER_LEN) first_reject = ST_BAD_TCP;
              end
            end
          end
          // position saturates at the frame limit
          frame_pos++;
        end

        // Queue the frame's result on its last byte
        if (s_axis_tlast) begin
          frames_done++;
          if (first_reject != ST_OK) want.status = first_reject;
          else if (tcp_len == 0) want.status = ST_TRUNCATED;
          else want.status = ST_OK;
          want.ip_hdr_bytes  = ip_len;
          want.tcp_hdr_bytes = tcp_len;
          if (want.status == ST_OK) begin
            want.src_addr = src_acc;
            want.dst_addr = dst_acc;
            want.src_port = sport_acc;
            want.dst_port = dport_acc;
            want.seq_num  = seq_acc;
            want.ack_num  = ack_acc;
          end else begin
            want.src_addr = '0;
            want.dst_addr = '0;
            want.src_port = '0;
            want.dst_port = '0;
            want.seq_num  = '0;
            want.ack_num  = '0;
          end
          want.pkt_num = frames_done;
          expected_headers.push_back(want);
          start_new_frame();
        end
      end
    end
    pending_results <= expected_headers.size();
  end

endmodule

/* test/tb_tcp_ipv4_header_extractor.sv */
// Testbench top for the header extractor: frame stimulus, result sink and final verdict.
`timescale 1ns / 1ps

module tb_tcp_ipv4_header_extractor;
  import hte_pkg::*;

  localparam int unsigned FRAME_LIMIT      = 65535;
  localparam int          TOTAL_BYTES      = 900;
  localparam int          RANDOM_FRAMES    = 14;
  localparam int          HOLD_OFF_CYCLES  = 400;
  localparam int          DRAIN_CYCLES     = 10;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef enum logic [2:0] {
    KIND_TCP,
    KIND_SHORT,
    KIND_BAD_ETYPE,
    KIND_BAD_IHL,
    KIND_NOT_TCP,
    KIND_BAD_DOFF,
    KIND_NOISE
  } frame_kind_t;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata  = 8'h00;
  logic         s_axis_tlast  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  int mismatch_count;
  int pending_results;
  int bytes_sent  = 0;
  int frames_sent = 0;
  bit hold_off_req = 1'b0;
  bit hold_active  = 1'b0;

  tcp_ipv4_header_extractor #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  header_result_checker #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_result_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offer one word and hold it until taken, then maybe idle a while
  task automatic send_byte(input logic [7:0] b, input logic last, input bit gaps);
    int r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 60) begin
        s_axis_tvalid <= 1'b0;
        if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
        else if (r < 98) repeat ($urandom_range(4, 12)) @(posedge clk);
        else repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  endtask

  // Build a frame on the fly: filler bytes with the parsed header bytes forced
  task automatic send_frame(input logic [7:0] et_hi, input logic [7:0] et_lo,
                            input logic [3:0] ihl, input logic [7:0] proto,
                            input logic [3:0] doff, input int len, input fill_t fill,
                            input bit gaps);
    int         tcp_at;
    int         p;
    logic [7:0] b;
    tcp_at = 14 + 4 * ihl;
    for (p = 0; p < len; p++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      if (p == 12) b = et_hi;
      else if (p == 13) b = et_lo;
      else if (p == 14) b = {b[7:4], ihl};  // version nibble stays filler
      else if (p == 23) b = proto;
      else if (p == tcp_at + 12) b = {doff, b[3:0]};
      send_byte(b, p == len - 1, gaps);
    end
    frames_sent++;
  endtask

  // Stimulus: directed frames, then random frames
  initial begin : frame_source
    frame_kind_t kind;
    int          r;
    int          len;
    int          hdr_end;
    logic [7:0]  et_hi;
    logic [7:0]  et_lo;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    logic [3:0]  doff;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single-byte frame: nothing reached
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd5, 1, FILL_RANDOM, 1'b0);
    // minimal good frames, all-zero and all-one fields
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd5, 47, FILL_ZERO, 1'b0);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd5, 54, FILL_ONES, 1'b1);
    // largest IPv4 and TCP headers
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd15, PROTO_TCP, 4'd15, 138, FILL_RANDOM, 1'b1);
    // wrong EtherType, high then low byte
    send_frame(8'hFF, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd5, 40, FILL_RANDOM, 1'b1);
    send_frame(ETYPE_IPV4_HI, 8'hFF, 4'd5, PROTO_TCP, 4'd5, 40, FILL_RANDOM, 1'b0);
    // IPv4 header length zero and just under the minimum
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd0, PROTO_TCP, 4'd5, 30, FILL_RANDOM, 1'b1);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd4, PROTO_TCP, 4'd5, 30, FILL_RANDOM, 1'b0);
    // not TCP
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, 8'd17, 4'd5, 30, FILL_RANDOM, 1'b1);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, 8'hFF, 4'd5, 30, FILL_RANDOM, 1'b0);
    // TCP data offset under the minimum, and zero
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd4, 60, FILL_RANDOM, 1'b1);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd6, PROTO_TCP, 4'd0, 60, FILL_RANDOM, 1'b0);
    // short frames: end at the length byte, before the data offset, at EtherType
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd5, 15, FILL_RANDOM, 1'b1);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, PROTO_TCP, 4'd5, 46, FILL_RANDOM, 1'b0);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd7, PROTO_TCP, 4'd5, 13, FILL_RANDOM, 1'b1);
    // first rejection wins over later ones
    send_frame(8'h86, 8'hDD, 4'd0, 8'd17, 4'd0, 30, FILL_RANDOM, 1'b1);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd3, 8'd17, 4'd0, 30, FILL_RANDOM, 1'b0);
    send_frame(ETYPE_IPV4_HI, ETYPE_IPV4_LO, 4'd5, 8'd1, 4'd2, 60, FILL_RANDOM, 1'b1);

    // Random frames fill up the byte budget
    frames_sent = 0;
    while (bytes_sent < TOTAL_BYTES || frames_sent < RANDOM_FRAMES) begin
      // Stall the result side and keep short frames coming so the input backs up
      if (frames_sent == 2 || frames_sent == 12) begin
        hold_off_req = 1'b1;
        wait (hold_active);
        repeat (8)
          send_frame(8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom), 4'($urandom),
                     $urandom_range(1, 3), FILL_RANDOM, 1'b0);
      end

      r = $urandom_range(0, 99);
      if (r < 50) kind = KIND_TCP;
      else if (r < 60) kind = KIND_SHORT;
      else if (r < 66) kind = KIND_BAD_ETYPE;
      else if (r < 72) kind = KIND_BAD_IHL;
      else if (r < 78) kind = KIND_NOT_TCP;
      else if (r < 85) kind = KIND_BAD_DOFF;
      else kind = KIND_NOISE;

      et_hi = ETYPE_IPV4_HI;
      et_lo = ETYPE_IPV4_LO;
      proto = PROTO_TCP;
      ihl   = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
      doff  = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom_range(5, 15));

      case (kind)
        KIND_BAD_ETYPE: begin
          // flip one bit of one EtherType byte
          if ($urandom_range(0, 1)) et_hi = et_hi ^ (8'h01 << $urandom_range(0, 7));
          else et_lo = et_lo ^ (8'h01 << $urandom_range(0, 7));
        end
        KIND_BAD_IHL:  ihl   = 4'($urandom_range(0, 4));
        KIND_NOT_TCP:  proto = PROTO_TCP ^ 8'($urandom_range(1, 255));
        KIND_BAD_DOFF: doff  = 4'($urandom_range(0, 4));
        KIND_NOISE: begin
          et_hi = 8'($urandom);
          et_lo = 8'($urandom);
          proto = 8'($urandom);
          ihl   = 4'($urandom);
          doff  = 4'($urandom);
        end
        default: ;
      endcase

      // frame length that ends with the TCP data offset byte
      hdr_end = 14 + 4 * ihl + 13;
      if (kind == KIND_SHORT) len = $urandom_range(1, hdr_end - 1);
      else if (kind == KIND_NOISE) len = $urandom_range(1, 48);
      else if ($urandom_range(0, 4) == 0) len = hdr_end;
      else len = 14 + 4 * ihl + 4 * doff + $urandom_range(0, 6);
      if (len < hdr_end && kind == KIND_TCP) len = hdr_end;

      send_frame(et_hi, et_lo, ihl, proto, doff, len, FILL_RANDOM, $urandom_range(0, 3) != 0);
    end

    // Drain outstanding results and give the verdict
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: ready in random stretches, plus long hold-offs on request
  initial begin : result_sink
    int mode;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(5, 40)) @(posedge clk);
        end else if (mode < 9) begin
          repeat ($urandom_range(5, 40)) begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
            @(posedge clk);
          end
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end
      end
    end
  end

  // Hard limit on run time
  initial begin : watchdog
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
